@@ src/clm_pkg.sv @@
// Shared types and codes for the caching lock table manager.
package clm_pkg;

  localparam int LOCK_ID_W   = 8;
  localparam int CLIENT_ID_W = 4;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RETRY   = 2'd1;
  localparam logic [1:0] STATUS_NOENT   = 2'd2;
  localparam logic [1:0] STATUS_ILLEGAL = 2'd3;

  localparam logic [1:0] NOTE_NONE   = 2'd0;
  localparam logic [1:0] NOTE_REVOKE = 2'd1;
  localparam logic [1:0] NOTE_RETRY  = 2'd2;

  typedef enum logic [1:0] {
    LS_FREE        = 2'd0,
    LS_LOCKED      = 2'd1,
    LS_LOCKED_WAIT = 2'd2,
    LS_RETRYING    = 2'd3
  } lock_state_e;

  typedef struct packed {
    logic                   command;
    logic [LOCK_ID_W-1:0]   lock_id;
    logic [CLIENT_ID_W-1:0] client_id;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [1:0]             notify_kind;
    logic [CLIENT_ID_W-1:0] notify_client;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

@@ src/clm_ram.sv @@
// Generic single-port-write RAM with registered read.
module clm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/clm_ctrl.sv @@
// Controller: sequences request capture and table write-back.
module clm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output clm_pkg::ctrl_cmd_t    cmd_o
);

  import clm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d == S_EXEC);
    end
  end

  assign busy_o         = busy_q;
  assign cmd_o.capture  = start_i && !busy_q;
  assign cmd_o.commit   = busy_q;

endmodule

@@ src/clm_datapath.sv @@
// Datapath: lock table, request registers and result computation.
module clm_datapath #(
  parameter int LOCK_COUNT   = 256,
  parameter int CLIENT_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clm_pkg::req_t      req_i,
  input  clm_pkg::ctrl_cmd_t cmd_i,
  output clm_pkg::rsp_t      rsp_o,
  output logic               rsp_valid_o
);

  import clm_pkg::*;

  localparam int IdSpan = 1 << LOCK_ID_W;
  localparam int CliSpan = 1 << CLIENT_ID_W;
  localparam int Depth = (LOCK_COUNT < IdSpan) ? LOCK_COUNT : IdSpan;
  localparam int Aw = $clog2(Depth);
  localparam int Cw = (CLIENT_COUNT < CliSpan) ? CLIENT_COUNT : CliSpan;
  localparam int Ciw = $clog2(Cw);
  localparam int Ew = 2 + CLIENT_ID_W + Cw;

  typedef logic [Aw-1:0] lock_map_t [IdSpan];
  typedef logic [Ciw-1:0] cli_map_t [CliSpan];

  function automatic lock_map_t build_lock_map();
    lock_map_t m;
    for (int i = 0; i < IdSpan; i++) begin
      m[i] = Aw'(i % LOCK_COUNT);
    end
    return m;
  endfunction

  function automatic cli_map_t build_cli_map();
    cli_map_t m;
    for (int i = 0; i < CliSpan; i++) begin
      m[i] = Ciw'(i % CLIENT_COUNT);
    end
    return m;
  endfunction

  function automatic logic [CLIENT_ID_W-1:0] lowest_waiter(logic [Cw-1:0] w);
    logic [CLIENT_ID_W-1:0] c;
    c = '0;
    for (int i = Cw - 1; i >= 0; i--) begin
      if (w[i]) begin
        c = CLIENT_ID_W'(i);
      end
    end
    return c;
  endfunction

  localparam lock_map_t LockMap = build_lock_map();
  localparam cli_map_t CliMap = build_cli_map();

  logic                   cmd_q;
  logic [Aw-1:0]          idx_q;
  logic [Ciw-1:0]         cli_q;
  logic [Depth-1:0]       present_q;
  rsp_t                   rsp_q, rsp_d;
  logic                   valid_q;

  logic [Ew-1:0]          rdata;
  logic [Ew-1:0]          wdata;
  logic                   present;
  lock_state_e            st_rd, st_d;
  logic [CLIENT_ID_W-1:0] own_rd, own_d, cli_ext;
  logic [Cw-1:0]          wait_rd, wait_d, me;

  clm_ram #(
    .WIDTH(Ew),
    .DEPTH(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(idx_q),
    .wdata_i(wdata),
    .raddr_i(LockMap[req_i.lock_id]),
    .rdata_o(rdata)
  );

  assign present = present_q[idx_q];
  assign st_rd   = present ? lock_state_e'(rdata[Ew-1 -: 2]) : LS_FREE;
  assign own_rd  = present ? rdata[Cw +: CLIENT_ID_W] : '0;
  assign wait_rd = present ? rdata[Cw-1:0] : '0;
  assign me      = Cw'(1) << cli_q;
  assign cli_ext = CLIENT_ID_W'(cli_q);

  always_comb begin
    st_d   = st_rd;
    own_d  = own_rd;
    wait_d = wait_rd;
    rsp_d  = '{status: STATUS_OK, notify_kind: NOTE_NONE, notify_client: '0};
    if (cmd_q == CMD_ACQUIRE) begin
      case (st_rd)
        LS_FREE: begin
          st_d  = LS_LOCKED;
          own_d = cli_ext;
        end
        LS_LOCKED: begin
          st_d                = LS_LOCKED_WAIT;
          wait_d              = wait_rd | me;
          rsp_d.status        = STATUS_RETRY;
          rsp_d.notify_kind   = NOTE_REVOKE;
          rsp_d.notify_client = own_rd;
        end
        LS_LOCKED_WAIT: begin
          wait_d       = wait_rd | me;
          rsp_d.status = STATUS_RETRY;
        end
        default: begin
          if (|(wait_rd & me)) begin
            wait_d = wait_rd & ~me;
            own_d  = cli_ext;
            if (|wait_d) begin
              st_d                = LS_LOCKED_WAIT;
              rsp_d.notify_kind   = NOTE_REVOKE;
              rsp_d.notify_client = cli_ext;
            end else begin
              st_d = LS_LOCKED;
            end
          end else begin
            wait_d       = wait_rd | me;
            rsp_d.status = STATUS_RETRY;
          end
        end
      endcase
    end else if (!present) begin
      rsp_d.status = STATUS_NOENT;
    end else begin
      case (st_rd)
        LS_LOCKED: begin
          st_d  = LS_FREE;
          own_d = '0;
        end
        LS_LOCKED_WAIT: begin
          st_d  = LS_RETRYING;
          own_d = '0;
          if (|wait_rd) begin
            rsp_d.notify_kind   = NOTE_RETRY;
            rsp_d.notify_client = lowest_waiter(wait_rd);
          end
        end
        default: rsp_d.status = STATUS_ILLEGAL;
      endcase
    end
  end

  assign wdata = {st_d, own_d, wait_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= req_i.command;
      idx_q <= LockMap[req_i.lock_id];
      cli_q <= CliMap[req_i.client_id];
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= cmd_i.commit;
      if (cmd_i.commit && cmd_q == CMD_ACQUIRE) begin
        present_q[idx_q] <= 1'b1;
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = valid_q;

endmodule

@@ src/caching_lock_table_manager_unit.sv @@
// Top level of the caching lock table manager.
// Each request (acquire or release of one lock by one client) is taken when
// start is high and busy is low, and gives exactly one result, registered
// once the table entry is updated, and shown for one cycle with
// result_valid_o high; the receiver cannot stall it. A request first reads
// the lock table memory, then updates the entry and registers the result;
// busy is high in the cycle after each accepted request, and no new request
// is taken while busy is high. The table is usable straight after reset;
// per-entry present bits clear it at once. Lock and client numbers wrap at
// LOCK_COUNT and CLIENT_COUNT.
module caching_lock_table_manager_unit #(
  parameter int LOCK_COUNT   = 256,
  parameter int CLIENT_COUNT = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  clm_pkg::req_t req_i,
  output clm_pkg::rsp_t rsp_o,
  output logic          result_valid_o
);

  import clm_pkg::*;

  ctrl_cmd_t cmd;

  clm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  clm_datapath #(
    .LOCK_COUNT  (LOCK_COUNT),
    .CLIENT_COUNT(CLIENT_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .rsp_o      (rsp_o),
    .rsp_valid_o(result_valid_o)
  );

endmodule

@@ test/clm_lock_checker.sv @@
// Checker for the caching lock table manager: tracks the lock table and compares each result.
`timescale 1ns / 100ps

module clm_lock_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  clm_pkg::req_t req_i,
  input  clm_pkg::rsp_t rsp_i,
  input  logic          valid_i,
  output int            error_count_o,
  output int            pending_o,
  output int            result_count_o,
  output int            notice_count_o
);

  import clm_pkg::*;

  localparam int LOCKS   = 1 << LOCK_ID_W;
  localparam int CLIENTS = 1 << CLIENT_ID_W;

  logic                   present_q [LOCKS];
  lock_state_e            state_q   [LOCKS];
  logic [CLIENT_ID_W-1:0] owner_q   [LOCKS];
  logic [CLIENTS-1:0]     waiters_q [LOCKS];

  rsp_t pending_grants[$];
  rsp_t oldest;
  int   errors  = 0;
  int   results = 0;
  int   notices = 0;
  int   waiting = 0;

  assign error_count_o  = errors;
  assign pending_o      = waiting;
  assign result_count_o = results;
  assign notice_count_o = notices;

  function automatic rsp_t grant_outcome(input req_t r);
    rsp_t               o;
    int unsigned        idx;
    logic [CLIENTS-1:0] me;
    o.status        = STATUS_OK;
    o.notify_kind   = NOTE_NONE;
    o.notify_client = '0;
    idx             = r.lock_id;
    me              = CLIENTS'(1) << r.client_id;
    if (r.command == CMD_ACQUIRE) begin
      if (!present_q[idx]) begin
        present_q[idx] = 1'b1;
        state_q[idx]   = LS_FREE;
        owner_q[idx]   = '0;
        waiters_q[idx] = '0;
      end
      case (state_q[idx])
        LS_FREE: begin
          state_q[idx] = LS_LOCKED;
          owner_q[idx] = r.client_id;
        end
        LS_LOCKED: begin
          state_q[idx]    = LS_LOCKED_WAIT;
          waiters_q[idx] |= me;
          o.status        = STATUS_RETRY;
          o.notify_kind   = NOTE_REVOKE;
          o.notify_client = owner_q[idx];
        end
        LS_LOCKED_WAIT: begin
          waiters_q[idx] |= me;
          o.status        = STATUS_RETRY;
        end
        default: begin
          if ((waiters_q[idx] & me) != '0) begin
            waiters_q[idx] &= ~me;
            owner_q[idx]    = r.client_id;
            if (waiters_q[idx] != '0) begin
              state_q[idx]    = LS_LOCKED_WAIT;
              o.notify_kind   = NOTE_REVOKE;
              o.notify_client = r.client_id;
            end else begin
              state_q[idx] = LS_LOCKED;
            end
          end else begin
            waiters_q[idx] |= me;
            o.status        = STATUS_RETRY;
          end
        end
      endcase
    end else if (!present_q[idx]) begin
      o.status = STATUS_NOENT;
    end else begin
      case (state_q[idx])
        LS_LOCKED: begin
          state_q[idx] = LS_FREE;
          owner_q[idx] = '0;
        end
        LS_LOCKED_WAIT: begin
          state_q[idx] = LS_RETRYING;
          owner_q[idx] = '0;
          if (waiters_q[idx] != '0) begin
            o.notify_kind = NOTE_RETRY;
            for (int c = CLIENTS - 1; c >= 0; c--) begin
              if (waiters_q[idx][c]) begin
                o.notify_client = CLIENT_ID_W'(c);
              end
            end
          end
        end
        default: begin
          o.status = STATUS_ILLEGAL;
        end
      endcase
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOCKS; i++) begin
        present_q[i] = 1'b0;
        state_q[i]   = LS_FREE;
        owner_q[i]   = '0;
        waiters_q[i] = '0;
      end
      pending_grants.delete();
      waiting = 0;
    end else begin
      if (start_i && !busy_i) begin
        pending_grants.push_back(grant_outcome(req_i));
      end
      if (valid_i) begin
        if (pending_grants.size() == 0) begin
          $error("result with no request outstanding: status %0d kind %0d client %0d",
                 rsp_i.status, rsp_i.notify_kind, rsp_i.notify_client);
          errors++;
        end else begin
          oldest = pending_grants.pop_front();
          results++;
          if (oldest.notify_kind != NOTE_NONE) begin
            notices++;
          end
          if (rsp_i.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, rsp_i.status);
            errors++;
          end
          if (rsp_i.notify_kind !== oldest.notify_kind) begin
            $error("notify_kind: expected %0d, got %0d", oldest.notify_kind,
                   rsp_i.notify_kind);
            errors++;
          end
          if (rsp_i.notify_client !== oldest.notify_client) begin
            $error("notify_client: expected %0d, got %0d", oldest.notify_client,
                   rsp_i.notify_client);
            errors++;
          end
        end
      end
      waiting = pending_grants.size();
    end
  end

endmodule

@@ test/caching_lock_table_manager_unit_tb.sv @@
// Testbench top for the caching lock table manager: drives requests and reports the verdict.
`timescale 1ns / 100ps

module caching_lock_table_manager_unit_tb;
  import clm_pkg::*;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int HOT_LOCKS       = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t req;
  rsp_t rsp;
  logic result_valid;

  int error_count;
  int pending;
  int result_count;
  int notice_count;
  int sent_total    = 0;
  int sent_directed = 0;
  int quiet_cycles  = 0;

  logic [LOCK_ID_W-1:0] hot_locks [HOT_LOCKS];

  caching_lock_table_manager_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .rsp_o          (rsp),
    .result_valid_o (result_valid)
  );

  clm_lock_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .rsp_i          (rsp),
    .valid_i        (result_valid),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .notice_count_o (notice_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic req_t lock_request(input logic cmd, input int lock, input int client);
    req_t r;
    r.command   = cmd;
    r.lock_id   = LOCK_ID_W'(lock);
    r.client_id = CLIENT_ID_W'(client);
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.command = ($urandom_range(99) < 55) ? CMD_ACQUIRE : CMD_RELEASE;
    if ($urandom_range(99) < 80) begin
      r.lock_id = hot_locks[$urandom_range(HOT_LOCKS - 1)];
    end else begin
      r.lock_id = LOCK_ID_W'($urandom);
    end
    if ($urandom_range(99) < 70) begin
      r.client_id = CLIENT_ID_W'($urandom_range(3));
    end else begin
      r.client_id = CLIENT_ID_W'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent_total++;
  endtask

  task automatic hold_idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  initial begin
    do begin
      @(posedge clk);
      if ((start && !busy) || result_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Timed out after %0d cycles with no request or result", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    req   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    hold_idle(2);

    // walk lock 255 through every state and notice, then exercise locks 0, 170 and 85
    send_request(lock_request(CMD_RELEASE, 255, 0));
    send_request(lock_request(CMD_ACQUIRE, 255, 15));
    send_request(lock_request(CMD_ACQUIRE, 255, 15));
    send_request(lock_request(CMD_ACQUIRE, 255, 3));
    send_request(lock_request(CMD_RELEASE, 255, 0));
    send_request(lock_request(CMD_RELEASE, 255, 7));
    send_request(lock_request(CMD_ACQUIRE, 255, 8));
    send_request(lock_request(CMD_ACQUIRE, 255, 3));
    send_request(lock_request(CMD_RELEASE, 255, 3));
    send_request(lock_request(CMD_ACQUIRE, 255, 8));
    send_request(lock_request(CMD_RELEASE, 255, 12));
    send_request(lock_request(CMD_ACQUIRE, 255, 15));
    send_request(lock_request(CMD_RELEASE, 255, 15));
    send_request(lock_request(CMD_RELEASE, 255, 15));
    send_request(lock_request(CMD_ACQUIRE, 0, 0));
    send_request(lock_request(CMD_ACQUIRE, 0, 1));
    send_request(lock_request(CMD_RELEASE, 0, 15));
    send_request(lock_request(CMD_ACQUIRE, 0, 0));
    send_request(lock_request(CMD_RELEASE, 170, 5));
    send_request(lock_request(CMD_ACQUIRE, 85, 10));
    sent_directed = sent_total;
    hold_idle(3);

    while (sent_total - sent_directed < RANDOM_REQUESTS) begin
      if ((sent_total - sent_directed) % 300 == 0) begin
        foreach (hot_locks[i]) hot_locks[i] = LOCK_ID_W'($urandom);
      end
      burst = $urandom_range(1, 20);
      repeat (burst) send_request(random_request());
      if ($urandom_range(3) != 0) begin
        hold_idle($urandom_range(1, 6));
      end
    end
    hold_idle(1);

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d lock requests (%0d directed) and checked %0d results,",
             sent_total, sent_directed, result_count);
    $display("%0d of them carrying a revoke or retry notice.", notice_count);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
